// ----- rtl/overwriting_ring_queue_average_defines.svh -----
// assertion macros shared by the queue checker
`ifndef OVERWRITING_RING_QUEUE_AVERAGE_DEFINES_SVH
`define OVERWRITING_RING_QUEUE_AVERAGE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ORQA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ORQA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/orqa_pkg.sv -----
// types and constants of the overwriting ring queue with running average
package orqa_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int INDEX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W       = 16;
   localparam int VALUE_W     = 16;
   localparam int OCC_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int SUM_W       = VALUE_W + $clog2(QUEUE_DEPTH) + 1;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int ENTRY_W     = TAG_W + VALUE_W;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_REMOVE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      action_type                 action;
      logic [TAG_W-1:0]           entry_tag;
      logic signed [VALUE_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  average;
      logic [TAG_W-1:0]           removed_tag;
      logic signed [VALUE_W-1:0]  removed_value;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

endpackage

// ----- rtl/orqa_ram.sv -----
// generic single-port-write ram with registered read
module orqa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/orqa_div.sv -----
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module orqa_div
   import orqa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [COUNT_W-1:0]       divisor,
   output logic                     done,
   output logic signed [SUM_W-1:0]  quotient
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W-1:0]  divisor_ff, divisor_in;
   logic                neg_ff, neg_in;
   logic [COUNT_W:0]    trial;
   logic [COUNT_W:0]    diff;

   // quo_ff shifts dividend bits out at the top and quotient bits in at the bottom
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(SUM_W - 1);
         rem_in     = '0;
         quo_in     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         divisor_in = divisor;
         neg_in     = dividend[SUM_W-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ----- rtl/overwriting_ring_queue_average.sv -----
// top level of the overwriting ring queue with running average
//
// Requests are taken one at a time; req_ready is high only while the block is
// idle. An insert into a queue that is not full goes from acceptance through
// ST_APPEND, which appends the entry, and ST_DIVIDE, where the bit-serial
// divider forms the average, kept as 16 bits, to ST_RESP, which presents the
// response; an insert into a full queue first passes ST_FETCH to drop the
// oldest entry. A remove passes ST_FETCH, which takes the registered read of
// the entry ram, and a remove on an empty queue goes straight to ST_RESP. The
// response then holds until rsp_ready, and the next request is taken in the cycle after that.
module overwriting_ring_queue_average
   import orqa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FETCH  = 6'b000010,
      ST_APPEND = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_RESP   = 6'b010000,
      ST_SPARE  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [INDEX_W-1:0]        head_ff, head_in;
   logic [INDEX_W-1:0]        tail_ff, tail_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   req_type                   req_ff, req_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      ram_wr_en;
   logic [ENTRY_W-1:0]        ram_rd_data;
   logic [TAG_W-1:0]          old_tag;
   logic signed [VALUE_W-1:0] old_value;
   logic                      div_start;
   logic                      div_done;
   logic signed [SUM_W-1:0]   div_quotient;

   function automatic logic [INDEX_W-1:0] next_slot(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] nxt;
      if (idx == INDEX_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

   assign old_tag   = ram_rd_data[ENTRY_W-1:VALUE_W];
   assign old_value = $signed(ram_rd_data[VALUE_W-1:0]);

   orqa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data ({req_ff.entry_tag, req_ff.entry_value}),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   orqa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      ram_wr_en = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.action == ACTION_REMOVE && count_ff == '0) begin
                  rsp_in   = '{status: STATUS_EMPTY, default: '0};
                  state_in = ST_RESP;
               end else if (req_data.action == ACTION_REMOVE
                            || count_ff == COUNT_W'(QUEUE_DEPTH)) begin
                  // head entry is read from the ram during this cycle
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_APPEND;
               end
            end
         end
         ST_FETCH: begin
            sum_in   = sum_ff - SUM_W'(old_value);
            head_in  = next_slot(head_ff);
            count_in = count_ff - 1'b1;
            if (req_ff.action == ACTION_REMOVE) begin
               rsp_in = '{status:        STATUS_REMOVED,
                          average:       '0,
                          removed_tag:   old_tag,
                          removed_value: old_value,
                          occupancy:     OCC_W'(count_in)};
               state_in = ST_RESP;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            ram_wr_en = 1'b1;
            tail_in   = next_slot(tail_ff);
            count_in  = count_ff + 1'b1;
            sum_in    = sum_ff + SUM_W'(req_ff.entry_value);
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               rsp_in = '{status:        STATUS_INSERTED,
                          average:       div_quotient[VALUE_W-1:0],
                          removed_tag:   '0,
                          removed_value: '0,
                          occupancy:     OCC_W'(count_ff)};
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/orqa_checker.sv -----
// port-level checker for the overwriting ring queue, bound to the top level
`include "overwriting_ring_queue_average_defines.svh"

module orqa_checker
   import orqa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one request in flight: never ready while a response is pending
   `ORQA_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready, "ready while response pending")

   // an accepted request closes the input until its response is taken
   `ORQA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
      "request accepted while previous one still open")

   // a response waits for the consumer
   `ORQA_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
      "response dropped or changed while stalled")

   // an insert always leaves at least one entry, never more than the depth
   `ORQA_ASSERT_NOW(a_insert_occupancy,
      rsp_valid && rsp_data.status == STATUS_INSERTED,
      rsp_data.occupancy != '0 && rsp_data.occupancy <= OCC_W'(QUEUE_DEPTH),
      "insert response with bad occupancy")

   // an empty-queue remove reports an empty queue
   `ORQA_ASSERT_NOW(a_empty_occupancy,
      rsp_valid && rsp_data.status == STATUS_EMPTY,
      rsp_data.occupancy == '0,
      "empty remove with nonzero occupancy")

endmodule

bind overwriting_ring_queue_average orqa_checker u_orqa_checker (.*);
